// ===== design/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types and constants for the indexed min-heap open list.
// ----------------------------------------------------------------------------
package imh_pkg;

	localparam int HEAP_DEPTH = 256;
	localparam int GRID_COLS  = 64;
	localparam int GRID_ROWS  = 64;
	localparam int CELLS      = GRID_COLS * GRID_ROWS;
	localparam int SLOT_W     = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int CELL_W     = $clog2(CELLS);
	localparam int COST_W     = 24;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_LOOKUP = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_DUP    = 2'd3;

	typedef struct packed {
		logic [CELL_W-1:0] pos;
		logic [11:0]       par;
		logic [COST_W-1:0] g;
		logic [COST_W-1:0] h;
		logic [COST_W-1:0] f;
	} heap_ent_t;

	typedef struct packed {
		logic              present;
		logic [SLOT_W-1:0] slot;
	} map_ent_t;

	typedef enum logic [2:0] {
		HR_LAST, HR_SLOT, HR_PARENT, HR_LEFT, HR_RIGHT, HR_TOP
	} hrd_sel_t;

	typedef enum logic [1:0] {
		E_NONE, E_IN, E_REM, E_UPD
	} e_sel_t;

	typedef struct packed {
		logic       ready;
		logic       cap_in;
		logic       map_rd;
		logic       clr_wr;
		logic       map_del;
		logic       hrd_en;
		hrd_sel_t   hrd;
		e_sel_t     e_sel;
		logic       ins_init;
		logic       slot_init;
		logic       cnt_dec;
		logic       up_swap;
		logic       dn_eval_l;
		logic       dn_eval_r;
		logic       dn_swap;
		logic       place;
		logic       st_load;
		logic [1:0] st_code;
		logic       fin_map;
		logic       fin_ent;
		logic       out_load;
	} imh_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       present;
		logic       slot_last;
		logic       full;
		logic       i_zero;
		logic       up_win;
		logic       l_ok;
		logic       r_ok;
		logic       v_is_i;
		logic       clr_done;
		logic       out_free;
	} imh_sts_t;

	// Final cost: actual plus heuristic, saturated to the cost width.
	function automatic logic [COST_W-1:0] final_cost(input logic [COST_W-1:0] g,
			input logic [COST_W-1:0] h);
		logic [COST_W:0] sum;
		sum = {1'b0, g} + {1'b0, h};
		return sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];
	endfunction

endpackage

// ===== design/imh_ctrl.sv =====
// ----------------------------------------------------------------------------
// imh_ctrl
// Sequencer for map clearing, heap operations, sift walks and result build.
// ----------------------------------------------------------------------------
module imh_ctrl import imh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  imh_sts_t sts,
	output imh_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_MRD, S_MAP, S_LOAD_REM, S_LOAD_UPD, S_UP_RD, S_UP_CMP,
		S_DN_RDL, S_DN_RDR, S_DN_CMPR, S_DN_DEC, S_PLACE, S_FIN, S_FIN2, S_FIN3
	} state_t;

	typedef enum logic [1:0] {D_FIN, D_PLACE, D_DOWN} after_t;

	state_t state_q, state_d;
	logic   moved_q, moved_d;
	after_t up_end;

	// Where a finished sift-up goes: inserts never sift down, and neither does
	// an entry that already moved up.
	always_comb begin
		up_end = (moved_q || sts.op == OP_INSERT) ? D_PLACE : D_DOWN;
	end

	always_comb begin
		cmd     = '0;
		cmd.hrd = HR_TOP;
		cmd.e_sel = E_NONE;
		state_d = state_q;
		moved_d = moved_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				// A new item waits while the previous result still has nowhere to go.
				cmd.ready  = sts.out_free;
				cmd.cap_in = 1'b1;
				moved_d    = 1'b0;
				if (in_fire) state_d = S_MRD;
			end
			S_MRD: begin
				cmd.map_rd = 1'b1;
				state_d    = S_MAP;
			end
			S_MAP: begin
				cmd.st_load = 1'b1;
				cmd.st_code = ST_OK;
				state_d     = S_FIN;
				if (sts.op == OP_INSERT) begin
					if (sts.present) begin
						cmd.st_code = ST_DUP;
					end else if (sts.full) begin
						cmd.st_code = ST_FULL;
					end else begin
						cmd.e_sel    = E_IN;
						cmd.ins_init = 1'b1;
						state_d      = S_UP_RD;
					end
				end else if (!sts.present) begin
					cmd.st_code = ST_ABSENT;
				end else if (sts.op == OP_REMOVE) begin
					cmd.map_del = 1'b1;
					cmd.cnt_dec = 1'b1;
					if (!sts.slot_last) begin
						cmd.hrd_en    = 1'b1;
						cmd.hrd       = HR_LAST;
						cmd.slot_init = 1'b1;
						state_d       = S_LOAD_REM;
					end
				end else if (sts.op == OP_UPDATE) begin
					cmd.hrd_en    = 1'b1;
					cmd.hrd       = HR_SLOT;
					cmd.slot_init = 1'b1;
					state_d       = S_LOAD_UPD;
				end
			end
			S_LOAD_REM: begin
				cmd.e_sel = E_REM;
				state_d   = S_UP_RD;
			end
			S_LOAD_UPD: begin
				cmd.e_sel = E_UPD;
				state_d   = S_UP_RD;
			end
			S_UP_RD: begin
				if (sts.i_zero) begin
					state_d = (up_end == D_PLACE) ? S_PLACE : S_DN_RDL;
				end else begin
					cmd.hrd_en = 1'b1;
					cmd.hrd    = HR_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_win) begin
					cmd.up_swap = 1'b1;
					moved_d     = 1'b1;
					state_d     = S_UP_RD;
				end else begin
					state_d = (up_end == D_PLACE) ? S_PLACE : S_DN_RDL;
				end
			end
			S_DN_RDL: begin
				if (sts.l_ok) begin
					cmd.hrd_en = 1'b1;
					cmd.hrd    = HR_LEFT;
					state_d    = S_DN_RDR;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_DN_RDR: begin
				cmd.dn_eval_l = 1'b1;
				if (sts.r_ok) begin
					cmd.hrd_en = 1'b1;
					cmd.hrd    = HR_RIGHT;
					state_d    = S_DN_CMPR;
				end else begin
					state_d = S_DN_DEC;
				end
			end
			S_DN_CMPR: begin
				cmd.dn_eval_r = 1'b1;
				state_d       = S_DN_DEC;
			end
			S_DN_DEC: begin
				if (sts.v_is_i) begin
					state_d = S_PLACE;
				end else begin
					cmd.dn_swap = 1'b1;
					state_d     = S_DN_RDL;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				cmd.map_rd = 1'b1;
				state_d    = S_FIN2;
			end
			S_FIN2: begin
				cmd.fin_map = 1'b1;
				cmd.hrd_en  = 1'b1;
				cmd.hrd     = HR_SLOT;
				state_d     = S_FIN3;
			end
			S_FIN3: begin
				cmd.fin_ent = 1'b1;
				cmd.hrd_en  = 1'b1;
				cmd.hrd     = HR_TOP;
				state_d     = S_IDLE;
				// Result is loaded from the idle state once the top read lands.
			end
			default: begin
				state_d = S_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			moved_q <= 1'b0;
		end else begin
			state_q <= state_d;
			moved_q <= moved_d;
		end
	end

endmodule

// ===== design/imh_dp.sv =====
// ----------------------------------------------------------------------------
// imh_dp
// Heap and cell map memories, moving-entry registers, compares and result.
// ----------------------------------------------------------------------------
module imh_dp import imh_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  imh_cmd_t      cmd,
	output imh_sts_t      sts,
	input  logic [1:0]    in_op,
	input  logic [5:0]    in_pos_x,
	input  logic [5:0]    in_pos_y,
	input  logic [5:0]    in_par_x,
	input  logic [5:0]    in_par_y,
	input  logic [23:0]   in_g,
	input  logic [23:0]   in_h,
	input  logic          cfg_wr_en,
	input  logic [8:0]    cfg_wr_data,
	input  logic          out_ready,
	output logic          out_valid,
	output logic [111:0]  out_data
);

	heap_ent_t heap_mem [HEAP_DEPTH];
	map_ent_t  map_mem  [CELLS];

	logic [1:0]        op_q;
	logic [CELL_W-1:0] cell_q;
	logic [11:0]       par_q;
	logic [23:0]       g_q, h_q;
	logic [8:0]        limit_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] i_q, v_q;
	heap_ent_t         e_q, best_q, heap_rd_q, ent_q;
	map_ent_t          map_rd_q;
	logic              found_q;
	logic [1:0]        status_q;
	logic [CELL_W-1:0] clr_q;
	logic              clr_done_q;
	logic              top_pend_q;
	logic              out_valid_q;
	logic [111:0]      out_q;

	logic [SLOT_W-1:0] p_idx, hrd_addr;
	logic [SLOT_W:0]   l_idx;
	logic [SLOT_W+1:0] r_idx;
	logic [CNT_W-1:0]  lim;
	logic              map_we, heap_we;
	logic [CELL_W-1:0] map_wa;
	map_ent_t          map_wd;
	logic [SLOT_W-1:0] heap_wa;
	heap_ent_t         heap_wd;
	logic              out_free;
	logic              found_out, has_top;

	assign p_idx = SLOT_W'((i_q - SLOT_W'(1)) >> 1);
	assign l_idx = {i_q, 1'b1};
	assign r_idx = {1'b0, l_idx} + (SLOT_W+2)'(1);
	assign lim   = (limit_q > 9'(HEAP_DEPTH)) ? CNT_W'(HEAP_DEPTH) : CNT_W'(limit_q);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (cmd.hrd)
			HR_LAST:   hrd_addr = SLOT_W'(cnt_q - CNT_W'(1));
			HR_SLOT:   hrd_addr = map_rd_q.slot;
			HR_PARENT: hrd_addr = p_idx;
			HR_LEFT:   hrd_addr = l_idx[SLOT_W-1:0];
			HR_RIGHT:  hrd_addr = r_idx[SLOT_W-1:0];
			default:   hrd_addr = '0;
		endcase
	end

	always_comb begin
		sts.op        = op_q;
		sts.present   = map_rd_q.present;
		sts.slot_last = ({1'b0, map_rd_q.slot} == (cnt_q - CNT_W'(1)));
		sts.full      = (cnt_q >= lim);
		sts.i_zero    = (i_q == '0);
		sts.up_win    = (e_q.f <= heap_rd_q.f);
		sts.l_ok      = ((CNT_W+1)'(l_idx) < (CNT_W+1)'(cnt_q));
		sts.r_ok      = (r_idx < (SLOT_W+2)'(cnt_q));
		sts.v_is_i    = (v_q == i_q);
		sts.clr_done  = clr_done_q;
		// No result is waiting, or the waiting one moves to the output now.
		sts.out_free  = !top_pend_q || out_free;
	end

	// Memory write port selection.
	always_comb begin
		map_we  = 1'b0;
		map_wa  = cell_q;
		map_wd  = '0;
		heap_we = 1'b0;
		heap_wa = i_q;
		heap_wd = e_q;
		if (cmd.clr_wr && !clr_done_q) begin
			map_we = 1'b1;
			map_wa = clr_q;
		end else if (cmd.map_del) begin
			map_we = 1'b1;
		end else if (cmd.up_swap) begin
			map_we  = 1'b1;
			map_wa  = heap_rd_q.pos;
			map_wd  = '{present: 1'b1, slot: i_q};
			heap_we = 1'b1;
			heap_wd = heap_rd_q;
		end else if (cmd.dn_swap) begin
			map_we  = 1'b1;
			map_wa  = best_q.pos;
			map_wd  = '{present: 1'b1, slot: i_q};
			heap_we = 1'b1;
			heap_wd = best_q;
		end else if (cmd.place) begin
			map_we  = 1'b1;
			map_wa  = e_q.pos;
			map_wd  = '{present: 1'b1, slot: i_q};
			heap_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		if (cmd.map_rd) map_rd_q <= map_mem[cell_q];
		if (heap_we) heap_mem[heap_wa] <= heap_wd;
		if (cmd.hrd_en) heap_rd_q <= heap_mem[hrd_addr];
	end

	// Payload and walk registers.
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q   <= in_op;
			cell_q <= {in_pos_y, in_pos_x};
			par_q  <= {in_par_y, in_par_x};
			g_q    <= in_g;
			h_q    <= in_h;
		end
		case (cmd.e_sel)
			E_IN:    e_q <= '{pos: cell_q, par: par_q, g: g_q, h: h_q,
					f: final_cost(g_q, h_q)};
			E_REM:   e_q <= heap_rd_q;
			E_UPD:   e_q <= '{pos: heap_rd_q.pos, par: par_q, g: g_q, h: heap_rd_q.h,
					f: final_cost(g_q, heap_rd_q.h)};
			default: e_q <= e_q;
		endcase
		if (cmd.ins_init) i_q <= cnt_q[SLOT_W-1:0];
		else if (cmd.slot_init) i_q <= map_rd_q.slot;
		else if (cmd.up_swap) i_q <= p_idx;
		else if (cmd.dn_swap) i_q <= v_q;
		if (cmd.dn_eval_l) begin
			if (e_q.f >= heap_rd_q.f) begin
				best_q <= heap_rd_q;
				v_q    <= l_idx[SLOT_W-1:0];
			end else begin
				best_q <= e_q;
				v_q    <= i_q;
			end
		end else if (cmd.dn_eval_r && best_q.f >= heap_rd_q.f) begin
			best_q <= heap_rd_q;
			v_q    <= r_idx[SLOT_W-1:0];
		end
		if (cmd.st_load) status_q <= cmd.st_code;
		if (cmd.fin_map) found_q <= map_rd_q.present;
		if (cmd.fin_ent) ent_q <= heap_rd_q;
	end

	assign found_out = found_q;
	assign has_top   = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= 9'd256;
			cnt_q       <= '0;
			clr_q       <= '0;
			clr_done_q  <= 1'b0;
			top_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) limit_q <= cfg_wr_data;
			if (cmd.ins_init) cnt_q <= cnt_q + CNT_W'(1);
			else if (cmd.cnt_dec) cnt_q <= cnt_q - CNT_W'(1);
			if (cmd.clr_wr && !clr_done_q) begin
				clr_q <= clr_q + CELL_W'(1);
				if (clr_q == CELL_W'(CELLS - 1)) clr_done_q <= 1'b1;
			end
			if (cmd.fin_ent) top_pend_q <= 1'b1;
			else if (top_pend_q && out_free) top_pend_q <= 1'b0;
			if (top_pend_q && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (top_pend_q && out_free) begin
			out_q <= {3'b000,
				~has_top,
				cnt_q,
				has_top ? heap_rd_q.g : 24'd0,
				has_top ? heap_rd_q.f : 24'd0,
				has_top ? heap_rd_q.pos[11:6] : 6'd0,
				has_top ? heap_rd_q.pos[5:0] : 6'd0,
				found_out ? ent_q.g : 24'd0,
				found_out ? ent_q.par[11:6] : 6'd0,
				found_out ? ent_q.par[5:0] : 6'd0,
				found_out,
				status_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== design/indexed_min_heap_open_list_top.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_open_list_top
// Open list for grid path search: indexed binary min-heap on final cost.
// ----------------------------------------------------------------------------
// Usage: each item on the s_axis channel is one operation (insert, remove,
// update of parent and actual cost, or lookup) on one grid cell. Every item
// returns exactly one result item on m_axis with the status, the addressed
// entry, the current heap top and the entry count.
// After reset the cell map is cleared, one cell per cycle, across all 4096
// cells; s_axis_tready stays low during that sweep. Configuration writes on
// cfg_wr_en / cfg_wr_data are taken at any time and set the entry limit.
// A lookup, a dropped operation or the removal of the last entry reads the
// cell map and goes straight to the result build. A sift reads the parent for
// each level climbed and both children for each level descended, as the heap
// memory has one read port; the worst case is an update walking down all
// eight levels of a full heap. One item is worked at a time, and the next one
// is taken in the cycle the result is registered. A result may wait in the
// output register while the next item is worked; if m_axis_tready stays low
// the second result holds inside the block and no further item is taken.
// ----------------------------------------------------------------------------
module indexed_min_heap_open_list_top import imh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// operation, pos_x, pos_y, parent_x, parent_y, actual_cost, heuristic_cost
	input  logic [79:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, found, entry_parent_x, entry_parent_y, entry_actual_cost, min_x,
	// min_y, min_final_cost, min_actual_cost, entry_count, is_empty
	output logic [111:0] m_axis_tdata,
	input  logic         cfg_wr_en,
	input  logic [8:0]   cfg_wr_data
);

	imh_cmd_t cmd;
	imh_sts_t sts;
	logic     in_fire;

	// The controller takes a new item only from its idle state.
	assign s_axis_tready = cmd.ready;
	assign in_fire       = s_axis_tvalid && cmd.ready;

	imh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.sts     (sts),
		.cmd     (cmd)
	);

	imh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_op       (s_axis_tdata[1:0]),
		.in_pos_x    (s_axis_tdata[7:2]),
		.in_pos_y    (s_axis_tdata[13:8]),
		.in_par_x    (s_axis_tdata[19:14]),
		.in_par_y    (s_axis_tdata[25:20]),
		.in_g        (s_axis_tdata[49:26]),
		.in_h        (s_axis_tdata[73:50]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_data    (m_axis_tdata)
	);

	// No item is taken while the cell map is still being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		!sts.clr_done |-> !s_axis_tready)
		else $error("item accepted during map clear");

	// The reported count never exceeds the heap depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[107:99] <= 9'(HEAP_DEPTH)))
		else $error("entry count beyond heap depth");

	// An empty heap reports a zero count and a zeroed top.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[108]) |->
		(m_axis_tdata[107:99] == 9'd0 && m_axis_tdata[98:39] == 60'd0))
		else $error("empty heap with nonzero top");

	// An absent cell reports a zeroed entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[38:3] == 36'd0))
		else $error("absent cell with nonzero entry");

endmodule
